// ----- hw/rtl/acss_pkg.sv -----
// ----------------------------------------------------------------------------
// acss_pkg
// Shared types, constants and helpers of the adc channel scan sequencer.
// ----------------------------------------------------------------------------
package acss_pkg;

    localparam int CHANNELS    = 8;
    localparam int ENTRY_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W       = $clog2(CHANNELS + 1);
    localparam int MAP_ENTRIES = 8;
    localparam int REF_SHIFT   = 6;
    localparam logic [3:0] CHAN_MASK = 4'h0f;
    localparam int ADDR_W      = 4;

    typedef enum logic [1:0] {
        ACT_START    = 2'd0,
        ACT_COMPLETE = 2'd1,
        ACT_QUERY    = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        REG_SAMPLE_COUNT     = 2'd0,
        REG_REFERENCE_SELECT = 2'd1,
        REG_CHANNEL_COUNT    = 2'd2,
        REG_CHANNEL_MAP      = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [7:0]  sample_count;
        logic [1:0]  reference_select;
        logic [3:0]  channel_count;
        logic [31:0] channel_map;
    } cfg_t;

    typedef struct packed {
        logic               en;
        logic [ENTRY_W-1:0] entry;
        logic [9:0]         value;
        logic [31:0]        time_us;
    } store_wr_t;

    typedef struct packed {
        logic               load;
        logic [ENTRY_W-1:0] addr_a;
        logic [ENTRY_W-1:0] addr_b;
        logic [ENTRY_W-1:0] qsel;
        logic [CNT_W-1:0]   cnt;
        store_wr_t          wr;
    } store_req_t;

    typedef struct packed {
        logic [9:0]  value;
        logic [31:0] time_us;
        logic [31:0] total;
    } store_rsp_t;

    // channel count clamped to the table depth
    function automatic logic [CNT_W-1:0] eff_count(input logic [3:0] count);
        logic [CNT_W-1:0] res;
        if (32'(count) > CHANNELS)
        begin
            res = CNT_W'(CHANNELS);
        end
        else
        begin
            res = CNT_W'(count);
        end
        return res;
    endfunction

    function automatic logic [7:0] mux_byte(input logic [3:0]  entry,
                                            input logic [1:0]  ref_sel,
                                            input logic [31:0] map);
        logic [31:0] sh;
        logic [3:0]  ch;
        sh = map >> {entry[2:0], 2'b00};
        ch = 4'd0;
        if (entry < 4'(MAP_ENTRIES))
        begin
            ch = sh[3:0] & CHAN_MASK;
        end
        return (8'(ref_sel) << REF_SHIFT) | 8'(ch);
    endfunction

endpackage

// ----- hw/rtl/acss_cfg.sv -----
// ----------------------------------------------------------------------------
// acss_cfg
// APB register bank: sample count, reference, channel count, channel map.
// ----------------------------------------------------------------------------
module acss_cfg import acss_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_SAMPLE_COUNT:     cfg_reg.sample_count     <= pwdata[7:0];
                REG_REFERENCE_SELECT: cfg_reg.reference_select <= pwdata[1:0];
                REG_CHANNEL_COUNT:    cfg_reg.channel_count    <= pwdata[3:0];
                REG_CHANNEL_MAP:      cfg_reg.channel_map      <= pwdata;
                default:              cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_SAMPLE_COUNT:     prdata = 32'(cfg_reg.sample_count);
            REG_REFERENCE_SELECT: prdata = 32'(cfg_reg.reference_select);
            REG_CHANNEL_COUNT:    prdata = 32'(cfg_reg.channel_count);
            REG_CHANNEL_MAP:      prdata = cfg_reg.channel_map;
            default:              prdata = '0;
        endcase
    end

endmodule

// ----- hw/rtl/acss_store.sv -----
// ----------------------------------------------------------------------------
// acss_store
// Per-entry result table: values in flops, times in a two-read-port memory,
// running prefix sums of the times for the total.
// ----------------------------------------------------------------------------
module acss_store import acss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  store_req_t req,
    output store_rsp_t rsp
);

    logic [9:0]         value_reg [CHANNELS];
    logic [31:0]        time_mem [CHANNELS];
    logic [CHANNELS-1:0] tvld_reg;
    logic [31:0]        prefix_reg [CHANNELS];
    logic [31:0]        rda_reg;
    logic [31:0]        rdb_reg;
    logic [31:0]        delta;
    logic [CNT_W-1:0]   cnt_m1;
    logic               hit_a;
    logic               hit_b;
    logic               wr_below;

    assign hit_a = req.wr.en && (req.wr.entry == req.addr_a);
    assign hit_b = req.wr.en && (req.wr.entry == req.addr_b);

    always_ff @(posedge clk)
    begin
        if (req.wr.en)
        begin
            time_mem[req.wr.entry] <= req.wr.time_us;
        end
    end

    // registered reads, with the write of the same edge forwarded
    always_ff @(posedge clk)
    begin
        if (req.load)
        begin
            if (hit_a)
            begin
                rda_reg <= req.wr.time_us;
            end
            else
            begin
                rda_reg <= tvld_reg[req.addr_a] ? time_mem[req.addr_a] : 32'd0;
            end
            if (hit_b)
            begin
                rdb_reg <= req.wr.time_us;
            end
            else
            begin
                rdb_reg <= tvld_reg[req.addr_b] ? time_mem[req.addr_b] : 32'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tvld_reg <= '0;
        end
        else if (req.wr.en)
        begin
            tvld_reg[req.wr.entry] <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                value_reg[i] <= '0;
            end
        end
        else if (req.wr.en)
        begin
            value_reg[req.wr.entry] <= req.wr.value;
        end
    end

    // old time of the written entry is on read port b
    assign delta = req.wr.time_us - rdb_reg;

    // prefix_reg[k] holds the sum of entries 0..k
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < CHANNELS; k++)
            begin
                prefix_reg[k] <= '0;
            end
        end
        else if (req.wr.en)
        begin
            for (int k = 0; k < CHANNELS; k++)
            begin
                if (32'(k) >= 32'(req.wr.entry))
                begin
                    prefix_reg[k] <= prefix_reg[k] + delta;
                end
            end
        end
    end

    assign cnt_m1   = req.cnt - CNT_W'(1);
    assign wr_below = req.wr.en && (CNT_W'(req.wr.entry) < req.cnt);

    always_comb
    begin
        if (req.wr.en && (req.wr.entry == req.qsel))
        begin
            rsp.value   = req.wr.value;
            rsp.time_us = req.wr.time_us;
        end
        else
        begin
            rsp.value   = value_reg[req.qsel];
            rsp.time_us = rda_reg;
        end
        if (req.cnt == '0)
        begin
            rsp.total = '0;
        end
        else
        begin
            rsp.total = prefix_reg[cnt_m1[ENTRY_W-1:0]] + (wr_below ? delta : 32'd0);
        end
    end

endmodule

// ----- hw/rtl/acss_ctrl.sv -----
// ----------------------------------------------------------------------------
// acss_ctrl
// Input register, scan sequencing state and result register.
// ----------------------------------------------------------------------------
module acss_ctrl import acss_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         action,
    input  logic [9:0]         sample_value,
    input  logic [31:0]        timestamp_us,
    input  logic [3:0]         query_channel,
    output store_req_t         sreq,
    input  store_rsp_t         srsp,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               start_accepted,
    output logic               start_conversion,
    output logic [7:0]         mux_select,
    output logic               scan_done,
    output logic               scan_busy,
    output logic [31:0]        scans_completed,
    output logic signed [10:0] read_value,
    output logic [31:0]        read_time,
    output logic [31:0]        total_time
);

    logic        advance;
    logic        process;
    logic        in_accept;

    logic        s1_valid_reg;
    logic [1:0]  s1_action_reg;
    logic [9:0]  s1_sample_reg;
    logic [31:0] s1_ts_reg;
    logic [3:0]  s1_q_reg;

    logic        busy_reg;
    logic        busy_next;
    logic [3:0]  entry_reg;
    logic [3:0]  entry_next;
    logic [7:0]  left_reg;
    logic [7:0]  left_next;
    logic [31:0] scans_reg;
    logic [31:0] scans_next;
    logic [31:0] req_time_reg;
    logic [31:0] req_time_next;

    logic        acc_c;
    logic        conv_c;
    logic        done_c;
    logic        wr_c;
    logic [7:0]  mux_c;
    logic [7:0]  left_dec;
    logic [3:0]  entry_inc;
    logic [CNT_W-1:0] cnt;
    logic        q_in_range;

    logic               out_valid_reg;
    logic               acc_reg;
    logic               conv_reg;
    logic [7:0]         mux_reg;
    logic               done_reg;
    logic               busy_out_reg;
    logic [31:0]        scans_out_reg;
    logic signed [10:0] rv_reg;
    logic [31:0]        rt_reg;
    logic [31:0]        tot_reg;

    assign advance   = !out_valid_reg || !out_stall;
    assign process   = s1_valid_reg && advance;
    assign in_stall  = s1_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (process)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_action_reg <= action;
            s1_sample_reg <= sample_value;
            s1_ts_reg     <= timestamp_us;
            s1_q_reg      <= query_channel;
        end
    end

    assign cnt       = eff_count(cfg.channel_count);
    assign left_dec  = left_reg - 8'd1;
    assign entry_inc = entry_reg + 4'd1;

    always_comb
    begin
        busy_next     = busy_reg;
        entry_next    = entry_reg;
        left_next     = left_reg;
        scans_next    = scans_reg;
        req_time_next = req_time_reg;
        acc_c         = 1'b0;
        conv_c        = 1'b0;
        done_c        = 1'b0;
        wr_c          = 1'b0;
        case (action_t'(s1_action_reg))
            ACT_START:
            begin
                if (!busy_reg)
                begin
                    busy_next  = 1'b1;
                    entry_next = 4'd0;
                    left_next  = cfg.sample_count;
                    acc_c      = 1'b1;
                    conv_c     = 1'b1;
                end
            end
            ACT_COMPLETE:
            begin
                if (busy_reg)
                begin
                    left_next = left_dec;
                    if (left_dec == 8'd0)
                    begin
                        wr_c       = (32'(entry_reg) < CHANNELS);
                        entry_next = entry_inc;
                        if (32'(entry_inc) >= 32'(cnt))
                        begin
                            scans_next = scans_reg + 32'd1;
                            busy_next  = 1'b0;
                            done_c     = 1'b1;
                        end
                        else
                        begin
                            left_next = cfg.sample_count;
                            conv_c    = 1'b1;
                        end
                    end
                    else
                    begin
                        conv_c = 1'b1;
                    end
                end
            end
            default:
            begin
                busy_next = busy_reg;
            end
        endcase
        mux_c = 8'd0;
        if (conv_c)
        begin
            mux_c         = mux_byte(entry_next, cfg.reference_select, cfg.channel_map);
            req_time_next = s1_ts_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            entry_reg    <= '0;
            left_reg     <= '0;
            scans_reg    <= '0;
            req_time_reg <= '0;
        end
        else if (process)
        begin
            busy_reg     <= busy_next;
            entry_reg    <= entry_next;
            left_reg     <= left_next;
            scans_reg    <= scans_next;
            req_time_reg <= req_time_next;
        end
    end

    // read port b follows the entry the next item will find
    always_comb
    begin
        sreq.load       = in_accept;
        sreq.addr_a     = query_channel[ENTRY_W-1:0];
        sreq.addr_b     = process ? entry_next[ENTRY_W-1:0] : entry_reg[ENTRY_W-1:0];
        sreq.qsel       = s1_q_reg[ENTRY_W-1:0];
        sreq.cnt        = cnt;
        sreq.wr.en      = process && wr_c;
        sreq.wr.entry   = entry_reg[ENTRY_W-1:0];
        sreq.wr.value   = s1_sample_reg;
        sreq.wr.time_us = s1_ts_reg - req_time_reg;
    end

    assign q_in_range = (32'(s1_q_reg) < 32'(cnt));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (process)
        begin
            acc_reg       <= acc_c;
            conv_reg      <= conv_c;
            mux_reg       <= mux_c;
            done_reg      <= done_c;
            busy_out_reg  <= busy_next;
            scans_out_reg <= scans_next;
            tot_reg       <= srsp.total;
            if (q_in_range)
            begin
                rv_reg <= 11'({1'b0, srsp.value});
                rt_reg <= srsp.time_us;
            end
            else
            begin
                rv_reg <= {11{1'b1}};
                rt_reg <= {32{1'b1}};
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign start_accepted   = acc_reg;
    assign start_conversion = conv_reg;
    assign mux_select       = mux_reg;
    assign scan_done        = done_reg;
    assign scan_busy        = busy_out_reg;
    assign scans_completed  = scans_out_reg;
    assign read_value       = rv_reg;
    assign read_time        = rt_reg;
    assign total_time       = tot_reg;

endmodule

// ----- hw/rtl/adc_channel_scan_sequencer_unit.sv -----
// ----------------------------------------------------------------------------
// adc_channel_scan_sequencer_unit
// Scans an ADC over a configured channel list, keeps the last sample and
// conversion time of each entry and reads them back per transaction.
//
//   channel   handshake            payload
//   in        in_valid/in_stall    action, sample_value, timestamp_us,
//                                  query_channel
//   out       out_valid/out_stall  start_accepted .. total_time
//   config    apb write/read       sample_count, reference_select,
//                                  channel_count, channel_map
//
// one transaction per cycle sustained while out is not stalled; a result
// passes through the input register, then the result register, to the outputs
// reset clears the sequencing state, the config registers and the result table
// a stall on out holds the result register and stalls in only once the
// input register is also full
// ----------------------------------------------------------------------------
module adc_channel_scan_sequencer_unit import acss_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         action,
    input  logic [9:0]         sample_value,
    input  logic [31:0]        timestamp_us,
    input  logic [3:0]         query_channel,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               start_accepted,
    output logic               start_conversion,
    output logic [7:0]         mux_select,
    output logic               scan_done,
    output logic               scan_busy,
    output logic [31:0]        scans_completed,
    output logic signed [10:0] read_value,
    output logic [31:0]        read_time,
    output logic [31:0]        total_time
);

    cfg_t       cfg;
    store_req_t sreq;
    store_rsp_t srsp;

    acss_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    acss_store u_store
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sreq),
        .rsp   (srsp)
    );

    acss_ctrl u_ctrl
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .action           (action),
        .sample_value     (sample_value),
        .timestamp_us     (timestamp_us),
        .query_channel    (query_channel),
        .sreq             (sreq),
        .srsp             (srsp),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .start_accepted   (start_accepted),
        .start_conversion (start_conversion),
        .mux_select       (mux_select),
        .scan_done        (scan_done),
        .scan_busy        (scan_busy),
        .scans_completed  (scans_completed),
        .read_value       (read_value),
        .read_time        (read_time),
        .total_time       (total_time)
    );

endmodule
